// ----- src/lbps_pkg.sv -----
package lbps_pkg;

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_START     = 2'd1,
        REQ_FORCE_ON  = 2'd2,
        REQ_FORCE_OFF = 2'd3
    } t_req;

    localparam logic [1:0]  PAT_POWER_UP  = 2'd0;
    localparam logic [1:0]  PAT_NOTIFY    = 2'd1;
    localparam logic [1:0]  PAT_NOTIFY_V2 = 2'd2;
    localparam logic [1:0]  PAT_INVALID   = 2'd3;

    localparam logic [1:0]  STEP_FIRST    = 2'd0;
    localparam logic [1:0]  STEP_SECOND   = 2'd1;

    localparam logic [15:0] REPEAT_FOREVER = 16'hFFFF;

    localparam int MS_W = 10;

    typedef struct packed {
        t_req        req_type;
        logic [1:0]  pattern_id;
        logic [15:0] repeat_count;
    } t_in_word;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic bad_pattern;
        logic finished;
    } t_out_word;

    // Duration of one step in ms. The third step of every pattern is the
    // terminator, and a step position past the table reads as one too.
    function automatic logic [MS_W-1:0] step_ms(input logic [1:0] pat, input logic [1:0] step);
        logic [MS_W-1:0] ms;
        ms = '0;
        case (pat)
            PAT_POWER_UP: begin
                if (step == STEP_FIRST) ms = 10'd100;
                else if (step == STEP_SECOND) ms = 10'd500;
            end
            PAT_NOTIFY: begin
                if (step == STEP_FIRST) ms = 10'd1;
                else if (step == STEP_SECOND) ms = 10'd1;
            end
            PAT_NOTIFY_V2: begin
                if (step == STEP_FIRST) ms = 10'd80;
                else if (step == STEP_SECOND) ms = 10'd1000;
            end
            default: ms = '0;
        endcase
        return ms;
    endfunction

    // All patterns start high and then stay low.
    function automatic logic step_level(input logic [1:0] step);
        return (step == STEP_FIRST);
    endfunction

endpackage

// ----- src/led_blink_pattern_sequencer_top.sv -----
// Channel   Direction  Handshake                   Word
// request   in         i_in_valid / o_in_ready     i_in_word  (t_in_word)
// result    out        o_out_valid / i_out_ready   o_out_word (t_out_word)
// config    in         i_cfg_we                    i_cfg_wdata (idle level)
//
// Each word is held in the input register and is then processed into the
// result register, from which its result is offered.
// A new word is accepted every cycle as long as the result side drains.
// Synchronous active-low reset clears all playback state and the idle level.
// A stalled result holds both registers; nothing is dropped.
module led_blink_pattern_sequencer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lbps_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lbps_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);
    import lbps_pkg::*;

    logic     stage_valid;
    logic     core_ready;
    t_in_word stage_word;

    lbps_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_valid    (stage_valid),
        .i_take     (core_ready),
        .o_word     (stage_word)
    );

    lbps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (stage_valid),
        .o_ready     (core_ready),
        .i_word      (stage_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- src/lbps_in_stage.sv -----
module lbps_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lbps_pkg::t_in_word i_in_word,
    output logic               o_valid,
    input  logic               i_take,
    output lbps_pkg::t_in_word o_word
);
    import lbps_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_word <= i_in_word;
        end
    end

endmodule

// ----- src/lbps_core.sv -----
module lbps_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  lbps_pkg::t_in_word  i_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lbps_pkg::t_out_word o_out_word
);
    import lbps_pkg::*;

    logic            r_idle;
    logic            r_running, n_running;
    logic [1:0]      r_sel, n_sel;
    logic [1:0]      r_step, n_step;
    logic [MS_W-1:0] r_ms_left, n_ms_left;
    logic [15:0]     r_passes, n_passes;
    logic [15:0]     r_target, n_target;
    logic            r_pin, n_pin;
    logic            n_bad, n_fin;
    logic [15:0]     pass_inc;
    logic            fire;

    logic      r_out_valid;
    t_out_word r_out_word;

    assign o_ready     = !r_out_valid || i_out_ready;
    assign fire        = i_valid && o_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign pass_inc    = r_passes + 16'd1;

    always_comb begin
        n_running = r_running;
        n_sel     = r_sel;
        n_step    = r_step;
        n_ms_left = r_ms_left;
        n_passes  = r_passes;
        n_target  = r_target;
        n_pin     = r_pin;
        n_bad     = 1'b0;
        n_fin     = 1'b0;
        case (i_word.req_type)
            REQ_START: begin
                if (i_word.pattern_id == PAT_INVALID) begin
                    n_bad     = 1'b1;
                    n_running = 1'b0;
                end else begin
                    n_sel     = i_word.pattern_id;
                    n_target  = i_word.repeat_count;
                    n_passes  = '0;
                    n_running = 1'b1;
                    n_pin     = step_level(STEP_FIRST) ^ r_idle;
                    n_ms_left = step_ms(i_word.pattern_id, STEP_FIRST);
                    n_step    = STEP_SECOND;
                end
            end
            REQ_FORCE_ON: begin
                n_pin     = ~r_idle;
                n_running = 1'b0;
            end
            REQ_FORCE_OFF: begin
                n_pin     = r_idle;
                n_running = 1'b0;
            end
            default: begin
                if (r_running) begin
                    if (r_ms_left > 10'd1) begin
                        n_ms_left = r_ms_left - 10'd1;
                    end else if (step_ms(r_sel, r_step) == '0) begin
                        // Terminator reached: one pass is over.
                        n_passes = pass_inc;
                        if (r_target != REPEAT_FOREVER && pass_inc >= r_target) begin
                            n_ms_left = '0;
                            n_pin     = r_idle;
                            n_running = 1'b0;
                            n_step    = STEP_FIRST;
                            n_fin     = 1'b1;
                        end else begin
                            n_pin     = step_level(STEP_FIRST) ^ r_idle;
                            n_ms_left = step_ms(r_sel, STEP_FIRST);
                            n_step    = STEP_SECOND;
                        end
                    end else begin
                        n_pin     = step_level(r_step) ^ r_idle;
                        n_ms_left = step_ms(r_sel, r_step);
                        n_step    = r_step + 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle      <= 1'b0;
            r_running   <= 1'b0;
            r_sel       <= '0;
            r_step      <= '0;
            r_ms_left   <= '0;
            r_passes    <= '0;
            r_target    <= '0;
            r_pin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_idle <= i_cfg_wdata;
            end
            if (fire) begin
                r_running <= n_running;
                r_sel     <= n_sel;
                r_step    <= n_step;
                r_ms_left <= n_ms_left;
                r_passes  <= n_passes;
                r_target  <= n_target;
                r_pin     <= n_pin;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word.pin_level   <= n_pin;
            r_out_word.busy_res    <= n_running;
            r_out_word.bad_pattern <= n_bad;
            r_out_word.finished    <= n_fin;
        end
    end

endmodule
